FILE: hw/rtl/hscm_pkg.sv
// ----------------------------------------------------------------------------
// hscm_pkg - shared types and constants for the hex spiral coordinate map
// Word layouts for both channels, the command codes, datapath widths and the
// reciprocal used to divide the square root, less three, by six.
// ----------------------------------------------------------------------------
package hscm_pkg;

  localparam int CELL_W   = 30;  // spiral cell number
  localparam int COORD_W  = 16;  // axial coordinate, signed
  localparam int RING_W   = 17;  // ring of any 16-bit coordinate pair
  localparam int KI_W     = 15;  // ring inside the legal range
  localparam int KF_W     = 15;  // ring of any 30-bit cell number
  localparam int RAD_W    = 34;  // 12 * n - 3
  localparam int ROOT_W   = 17;  // floor square root of the radicand
  localparam int ISQ_W    = RAD_W + 1;
  localparam int ISQ_STEPS = ROOT_W;
  localparam int SIDE_W   = 20;  // signed offsets along a ring
  localparam int PROD_W   = 30;  // k * (k - 1) for the inverse path
  localparam int FPROD_W  = 2 * KF_W + 1;
  localparam int HI_W     = 33;

  localparam int MAX_RING_DEF = 16384;

  // floor(t / 6) == (t * RECIP_6) >> RECIP_SH for t < 2**17
  localparam int RECIP_6  = 43691;
  localparam int RECIP_SH = 18;
  localparam int QUOT_W   = ROOT_W + 16;

  typedef enum logic {
    CMD_TO_COORD  = 1'b0,
    CMD_TO_NUMBER = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                      command;
    logic [CELL_W-1:0]         cell_number;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } hscm_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [CELL_W-1:0]         out_number;
    logic                      range_error;
  } hscm_out_t;

  // what rides alongside the square root
  typedef struct packed {
    cmd_t              cmd;
    logic [CELL_W-1:0] n;
    logic [CELL_W-1:0] num;
    logic              err;
  } hscm_tag_t;

endpackage

FILE: hw/rtl/hscm_isqrt.sv
// ----------------------------------------------------------------------------
// hscm_isqrt - pipelined integer square root
// One restoring step per stage, one root bit per stage, with a tag word
// carried in step. Each stage holds only while its successor is full.
// ----------------------------------------------------------------------------
module hscm_isqrt import hscm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RAD_W-1:0]  in_rad,
  input  hscm_tag_t         in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROOT_W-1:0] out_root,
  output hscm_tag_t         out_tag
);

  logic             v   [ISQ_STEPS];
  logic [ISQ_W-1:0] rem [ISQ_STEPS];
  logic [ISQ_W-1:0] res [ISQ_STEPS];
  hscm_tag_t        tag [ISQ_STEPS];
  logic [ISQ_STEPS-1:0] en;

  // stage advances when empty or when the one after it advances
  always_comb begin
    en[ISQ_STEPS-1] = !v[ISQ_STEPS-1] || out_ready;
    for (int i = ISQ_STEPS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_stage
    localparam logic [ISQ_W-1:0] BITV = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - g));
    logic             v_in;
    logic [ISQ_W-1:0] rem_in;
    logic [ISQ_W-1:0] res_in;
    hscm_tag_t        tag_in;
    logic             take;

    if (g == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = ISQ_W'(in_rad);
      assign res_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = v[g-1];
      assign rem_in = rem[g-1];
      assign res_in = res[g-1];
      assign tag_in = tag[g-1];
    end

    assign take = rem_in >= (res_in + BITV);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (en[g]) begin
        v[g] <= v_in;
      end
      if (en[g]) begin
        rem[g] <= take ? (rem_in - (res_in + BITV)) : rem_in;
        res[g] <= take ? ((res_in >> 1) + BITV) : (res_in >> 1);
        tag[g] <= tag_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[ISQ_STEPS-1];
  assign out_root  = res[ISQ_STEPS-1][ROOT_W-1:0];
  assign out_tag   = tag[ISQ_STEPS-1];

endmodule

FILE: hw/rtl/hex_spiral_coordinate_map.sv
// ----------------------------------------------------------------------------
// hex_spiral_coordinate_map - hexagonal spiral number <-> axial coordinates
// Converts a cell number of the hex spiral to (x, y), or (x, y) back to the
// cell number, selected per word by the command field.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is taken every clock while item_ready is high,
// and it passes 3 front stages, a 17-stage square root that produces one
// root bit per stage and 4 back stages ending in the output register. The
// square root is the longest part. Every stage keeps its own valid bit
// and moves whenever it is empty or its successor moves, so a stalled result
// only freezes the stages behind it that are full; bubbles keep filling and
// item_ready stays high until the whole pipe is backed up.
// Forward words (cell -> coordinates): the ring comes from
// floor(sqrt(12n-3)), minus 3, divided by 6 through a reciprocal multiply,
// then bumped by one when n lies past the ring's last cell. Cell number 0
// is treated as cell 1. Inverse words (coordinates -> cell): the ring comes
// from the signs and magnitudes of x and y; a ring beyond MAX_RING sets
// range_error and returns number 0. Unused result fields read as zero.
// ----------------------------------------------------------------------------
module hex_spiral_coordinate_map import hscm_pkg::*; #(
  parameter int MAX_RING = MAX_RING_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  hscm_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output hscm_out_t result
);

  localparam logic [RING_W-1:0] MAX_K = RING_W'(MAX_RING);

  // -------------------------------------------------------------------------
  // stage enables, back to front
  // -------------------------------------------------------------------------
  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;
  logic isq_in_ready, isq_out_valid;

  assign en_g = !g_v || result_ready;
  assign en_f = !f_v || en_g;
  assign en_e = !e_v || en_f;
  assign en_d = !d_v || en_e;
  assign en_c = !c_v || isq_in_ready;
  assign en_b = !b_v || en_c;
  assign en_a = !a_v || en_b;
  assign item_ready = en_a;

  // -------------------------------------------------------------------------
  // stage A: radicand for forward, ring for inverse
  // -------------------------------------------------------------------------
  logic [CELL_W-1:0] n_in;
  logic signed [SIDE_W-1:0] xi, yi;
  logic [RING_W-1:0] k_in;

  assign n_in = (item.cell_number == '0) ? CELL_W'(1) : item.cell_number;
  assign xi   = SIDE_W'(item.coord_x);
  assign yi   = SIDE_W'(item.coord_y);

  always_comb begin
    logic signed [SIDE_W-1:0] kr;
    if (!xi[SIDE_W-1] && !yi[SIDE_W-1]) begin
      kr = xi + yi;
    end else if (xi[SIDE_W-1] && yi[SIDE_W-1]) begin
      kr = -xi - yi;
    end else if (!xi[SIDE_W-1]) begin
      kr = (-yi < xi) ? xi : -yi;
    end else begin
      kr = (-xi < yi) ? yi : -xi;
    end
    k_in = kr[RING_W-1:0];
  end

  cmd_t                     a_cmd;
  logic [CELL_W-1:0]        a_n;
  logic [RAD_W-1:0]         a_rad;
  logic signed [SIDE_W-1:0] a_x, a_y;
  logic [RING_W-1:0]        a_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en_a) begin
      a_v <= item_valid;
    end
    if (en_a) begin
      a_cmd <= item.command;
      a_n   <= n_in;
      a_rad <= (RAD_W'(n_in) << 3) + (RAD_W'(n_in) << 2) - RAD_W'(3);
      a_x   <= xi;
      a_y   <= yi;
      a_k   <= k_in;
    end
  end

  // -------------------------------------------------------------------------
  // stage B: inverse k*(k-1) and the offset from the ring base
  // -------------------------------------------------------------------------
  logic signed [SIDE_W-1:0] kk, delta;
  logic [KI_W-1:0]          a_k15;

  assign a_k15 = a_k[KI_W-1:0];
  assign kk    = SIDE_W'({1'b0, a_k15});

  always_comb begin
    if (!a_x[SIDE_W-1]) begin
      if (!a_y[SIDE_W-1]) begin
        delta = (a_y != '0) ? (a_y - 20'sd1) : (kk * 20'sd6 - 20'sd1);
      end else begin
        delta = (kk == a_x) ? (kk * 20'sd6 - 20'sd1 + a_y)
                            : (kk * 20'sd4 - 20'sd1 + a_x);
      end
    end else begin
      if (!a_y[SIDE_W-1]) begin
        delta = (kk == a_y) ? (kk - 20'sd1 - a_x) : (kk * 20'sd3 - 20'sd1 - a_y);
      end else begin
        delta = kk * 20'sd4 - 20'sd1 + a_x;
      end
    end
  end

  cmd_t                     b_cmd;
  logic [CELL_W-1:0]        b_n;
  logic [RAD_W-1:0]         b_rad;
  logic [PROD_W-1:0]        b_prod;
  logic signed [SIDE_W-1:0] b_delta;
  logic                     b_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en_b) begin
      b_v <= a_v;
    end
    if (en_b) begin
      b_cmd   <= a_cmd;
      b_n     <= a_n;
      b_rad   <= a_rad;
      b_prod  <= PROD_W'(a_k15) * (PROD_W'(a_k15) - PROD_W'(1));
      b_delta <= delta;
      b_err   <= a_k > MAX_K;
    end
  end

  // -------------------------------------------------------------------------
  // stage C: inverse number = 3k(k-1) + 2 + delta
  // -------------------------------------------------------------------------
  logic [31:0] num_sum;

  assign num_sum = 32'(b_prod) + (32'(b_prod) << 1) + 32'd2 + 32'(b_delta);

  hscm_tag_t        c_tag;
  logic [RAD_W-1:0] c_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en_c) begin
      c_v <= b_v;
    end
    if (en_c) begin
      c_tag.cmd <= b_cmd;
      c_tag.n   <= b_n;
      c_tag.num <= b_err ? '0 : num_sum[CELL_W-1:0];
      c_tag.err <= b_err;
      c_rad     <= b_rad;
    end
  end

  // -------------------------------------------------------------------------
  // square root of 12n - 3
  // -------------------------------------------------------------------------
  logic [ROOT_W-1:0] isq_root;
  hscm_tag_t         isq_tag;

  hscm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_v),
    .in_ready  (isq_in_ready),
    .in_rad    (c_rad),
    .in_tag    (c_tag),
    .out_valid (isq_out_valid),
    .out_ready (en_d),
    .out_root  (isq_root),
    .out_tag   (isq_tag)
  );

  // -------------------------------------------------------------------------
  // stage D: (s - 3) times the reciprocal of 6
  // -------------------------------------------------------------------------
  logic [ROOT_W-1:0] s_m3;
  logic [QUOT_W-1:0] d_q;
  hscm_tag_t         d_tag;

  assign s_m3 = (isq_root >= ROOT_W'(3)) ? (isq_root - ROOT_W'(3)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en_d) begin
      d_v <= isq_out_valid;
    end
    if (en_d) begin
      d_q   <= QUOT_W'(s_m3) * QUOT_W'(RECIP_6);
      d_tag <= isq_tag;
    end
  end

  // -------------------------------------------------------------------------
  // stage E: first ring guess k0 and k0*(k0+1)
  // -------------------------------------------------------------------------
  logic [KF_W-1:0]    k0;
  logic [KF_W:0]      k0p1;
  logic [KF_W-1:0]    e_k0;
  logic [FPROD_W-1:0] e_m;
  hscm_tag_t          e_tag;

  assign k0   = d_q[RECIP_SH +: KF_W];
  assign k0p1 = {1'b0, k0} + (KF_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en_e) begin
      e_v <= d_v;
    end
    if (en_e) begin
      e_k0  <= k0;
      e_m   <= FPROD_W'(k0) * FPROD_W'(k0p1);
      e_tag <= d_tag;
    end
  end

  // -------------------------------------------------------------------------
  // stage F: guess may be one ring short; offset from the ring base
  // -------------------------------------------------------------------------
  logic [HI_W-1:0] hi1, base;
  logic            bump;
  logic [HI_W-1:0] off_full;

  assign hi1      = HI_W'(e_m) + (HI_W'(e_m) << 1) + HI_W'(2);
  assign bump     = HI_W'(e_tag.n) >= hi1;
  assign base     = bump ? hi1 : (hi1 - HI_W'(e_k0) * HI_W'(6));
  assign off_full = HI_W'(e_tag.n) - base;

  logic [KF_W-1:0]          f_k;
  logic signed [SIDE_W-1:0] f_off;
  hscm_tag_t                f_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en_f) begin
      f_v <= e_v;
    end
    if (en_f) begin
      f_k   <= bump ? (e_k0 + KF_W'(1)) : e_k0;
      f_off <= off_full[SIDE_W-1:0];
      f_tag <= e_tag;
    end
  end

  // -------------------------------------------------------------------------
  // stage G: pick the side of the ring, output register
  // -------------------------------------------------------------------------
  logic signed [SIDE_W-1:0] kf, fx, fy;

  assign kf = SIDE_W'({1'b0, f_k});

  always_comb begin
    if (f_off < kf) begin
      fx = kf - 20'sd1 - f_off;
      fy = f_off + 20'sd1;
    end else if (f_off < kf * 20'sd2) begin
      fx = kf - 20'sd1 - f_off;
      fy = kf;
    end else if (f_off < kf * 20'sd3) begin
      fx = -kf;
      fy = kf * 20'sd3 - 20'sd1 - f_off;
    end else if (f_off < kf * 20'sd4) begin
      fx = f_off - kf * 20'sd4 + 20'sd1;
      fy = kf * 20'sd3 - 20'sd1 - f_off;
    end else if (f_off < kf * 20'sd5) begin
      fx = f_off - kf * 20'sd4 + 20'sd1;
      fy = -kf;
    end else begin
      fx = kf;
      fy = f_off - kf * 20'sd6 + 20'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en_g) begin
      g_v <= f_v;
    end
    if (en_g) begin
      if (f_tag.cmd == CMD_TO_COORD) begin
        result.out_x       <= fx[COORD_W-1:0];
        result.out_y       <= fy[COORD_W-1:0];
        result.out_number  <= '0;
        result.range_error <= 1'b0;
      end else begin
        result.out_x       <= '0;
        result.out_y       <= '0;
        result.out_number  <= f_tag.num;
        result.range_error <= f_tag.err;
      end
    end
  end

  assign result_valid = g_v;

endmodule
